>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that a cause is followed by an effect in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// Types, constants and helpers for the MurmurHash3 x86_32 key hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package mm3_pkg;

	localparam logic [31:0] SEED_RESET = 32'h183d1db4;
	localparam logic [31:0] MUR_C1     = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2     = 32'h1b873593;
	localparam logic [31:0] MUR_ADD    = 32'he6546b64;
	localparam logic [31:0] MUR_F1     = 32'h85ebca6b;
	localparam logic [31:0] MUR_F2     = 32'hc2b2ae35;
	localparam int unsigned SHARD_BITS = 10;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last;
	} key_beat_t;

	typedef struct packed {
		logic [31:0]           hash;
		logic [SHARD_BITS-1:0] shard;
	} hash_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SC1,
		ST_SC2,
		ST_MIX,
		ST_AV1,
		ST_AV2,
		ST_EMIT
	} mm3_state_t;

	// Controls for the shared multiplier.
	typedef struct packed {
		logic        en;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	// Keep the low count bytes of a word.
	function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
		logic [31:0] m;
		case (cnt)
			3'd0:    m = 32'h0000_0000;
			3'd1:    m = 32'h0000_00ff;
			3'd2:    m = 32'h0000_ffff;
			3'd3:    m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> rtl/mm3_mul.sv
// ----------------------------------------------------------------------------
// mm3_mul
// Shared 32x32 multiplier, low word of the product, registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mm3_pkg::mul_req_t req,
	output logic [31:0]            product
);
	import mm3_pkg::*;

	logic [31:0] prod_lo;
	logic [31:0] product_q;

	assign prod_lo = req.a * req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_q <= '0;
		end else if (req.en) begin
			product_q <= prod_lo;
		end
	end

	assign product = product_q;

endmodule

`default_nettype wire

>>> rtl/murmur3_32_key_hash.sv
// ----------------------------------------------------------------------------
// murmur3_32_key_hash
// MurmurHash3 x86_32 over a key streamed as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   key channel (key_valid/key_stall/key_data): one beat per key word, first
//   byte in bits 7:0. byte_count is 4 for every word but the last; a word of
//   0..3 bytes always ends the key, counts above 4 act as 4.
//   hash channel (hash_valid/hash_stall/hash_data): one beat per key with the
//   hash and its low ten bits as shard.
//   cfg_we/cfg_wdata write the seed, loaded at the first word of each key.
// Sequencing:
//   One shared multiplier runs the scramble (two multiplies) and the
//   finalizer (two multiplies) in turn. A full non-final word runs SC1, SC2,
//   MIX; a final one goes on via AV1, AV2, EMIT to a registered result; an
//   empty one starts at AV1. key_stall is high while a word is in work.
// Reset clears the sequencer, the byte length, the mid-key flag and the
// output valid, and sets the seed to 0x183d1db4. While hash_stall holds a
// result, the next key can be taken and hashed; its result waits in the emit
// step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module murmur3_32_key_hash (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [31:0]         cfg_wdata,
	input  wire logic                key_valid,
	output logic                     key_stall,
	input  wire mm3_pkg::key_beat_t  key_data,
	output logic                     hash_valid,
	input  wire logic                hash_stall,
	output mm3_pkg::hash_beat_t      hash_data
);
	import mm3_pkg::*;

	mm3_state_t  state_q, state_nxt;
	logic [31:0] seed_q;
	logic [31:0] hash_q;
	logic [31:0] len_q;
	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic        fin_q;
	logic        mid_q;
	logic        hash_valid_q;
	hash_beat_t  hash_data_q;

	mul_req_t    mul_req;
	logic [31:0] product;

	logic        accept;
	logic [2:0]  cnt_in;
	logic        fin_in;
	logic [31:0] mix_x;
	logic [31:0] mix_r;
	logic [31:0] av1_t;
	logic [31:0] av2_t;
	logic [31:0] fin_h;
	logic        out_free;
	logic        load_out;

	mm3_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.product (product)
	);

	assign accept   = key_valid && !key_stall;
	assign cnt_in   = key_data.byte_count[2] ? 3'd4 : key_data.byte_count;
	assign fin_in   = key_data.last || !cnt_in[2];
	assign out_free = !hash_valid_q || !hash_stall;

	// Body and finalizer datapath around the shared multiplier.
	assign mix_x = hash_q ^ product;
	assign mix_r = {mix_x[18:0], mix_x[31:19]};
	assign av1_t = (hash_q ^ len_q) ^ {16'h0000, hash_q[31:16] ^ len_q[31:16]};
	assign av2_t = product ^ {13'h0000, product[31:13]};
	assign fin_h = product ^ {16'h0000, product[31:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		key_stall = 1'b1;
		load_out  = 1'b0;
		mul_req   = '{en: 1'b0, a: word_q, b: MUR_C1};
		case (state_q)
			ST_IDLE: begin
				key_stall = 1'b0;
				if (key_valid) begin
					if (cnt_in == 3'd0) begin
						state_nxt = ST_AV1;
					end else begin
						state_nxt = ST_SC1;
					end
				end
			end
			ST_SC1: begin
				mul_req   = '{en: 1'b1, a: word_q, b: MUR_C1};
				state_nxt = ST_SC2;
			end
			ST_SC2: begin
				mul_req   = '{en: 1'b1, a: {product[16:0], product[31:17]}, b: MUR_C2};
				state_nxt = ST_MIX;
			end
			ST_MIX: begin
				state_nxt = fin_q ? ST_AV1 : ST_IDLE;
			end
			ST_AV1: begin
				mul_req   = '{en: 1'b1, a: av1_t, b: MUR_F1};
				state_nxt = ST_AV2;
			end
			ST_AV2: begin
				mul_req   = '{en: 1'b1, a: av2_t, b: MUR_F2};
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// Key state: running hash, byte length, mid-key flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			len_q <= '0;
		end else if (accept) begin
			len_q <= (mid_q ? len_q : 32'h0) + {29'h0, cnt_in};
		end else if (state_q == ST_MIX && !fin_q) begin
			mid_q <= 1'b1;
		end else if (load_out) begin
			mid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= key_data.data_word & byte_mask(cnt_in);
			cnt_q  <= cnt_in;
			fin_q  <= fin_in;
			hash_q <= mid_q ? hash_q : seed_q;
		end else if (state_q == ST_MIX) begin
			if (cnt_q[2]) begin
				hash_q <= {mix_r[29:0], 2'b00} + mix_r + MUR_ADD;
			end else begin
				hash_q <= mix_x;
			end
		end
	end

	// Output register: hold while stalled, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if (load_out) begin
			hash_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			hash_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hash_data_q.hash  <= fin_h;
			hash_data_q.shard <= fin_h[SHARD_BITS-1:0];
		end
	end

	assign hash_valid = hash_valid_q;
	assign hash_data  = hash_data_q;

	`ASSERT_IMPL(a_shard_low_bits, clk, arst_n, hash_valid, hash_data.shard == hash_data.hash[SHARD_BITS-1:0], "shard differs from low hash bits")
	`ASSERT_PROP(a_full_word_turn, clk, arst_n, accept && key_data.byte_count[2] && !key_data.last |-> ##4 !key_stall, "full body word did not finish in four cycles")
	`ASSERT_PROP(a_result_from_emit, clk, arst_n, $rose(hash_valid) |-> $past(state_q == ST_EMIT), "result appeared outside the emit step")
	`ASSERT_PROP(a_empty_key_final, clk, arst_n, accept && key_data.byte_count == 3'd0 |=> state_q == ST_AV1, "empty word did not go to finalization")

endmodule

`default_nettype wire
